@@ rtl/tcw_pkg.sv @@
// Package: shared constants, types and helpers for the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int COL_W   = $clog2(COLUMNS + 1);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int CELL_W  = 16;

    localparam logic [7:0]        CH_NUL     = 8'h00;
    localparam logic [7:0]        CH_BS      = 8'h08;
    localparam logic [7:0]        CH_LF      = 8'h0a;
    localparam logic [7:0]        CH_CR      = 8'h0d;
    localparam logic [7:0]        CH_SPACE   = 8'h20;
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_SET   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef struct packed {
        op_t              operation;
        logic [7:0]       char_code;
        logic [COL_W-1:0] target_col;
        logic [ROW_W-1:0] target_row;
    } cmd_t;

    typedef struct packed {
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
        logic [7:0]       read_char;
        logic [7:0]       read_attr;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_DRAIN,
        ST_IDLE,
        ST_PUT,
        ST_RDCAP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PUT,
        RET_DONE
    } ret_t;

    typedef enum logic [1:0] {
        WR_BLANK,
        WR_COPY,
        WR_CHAR
    } wr_mode_t;

    typedef struct packed {
        logic              valid;
        wr_mode_t          mode;
        logic [ADDR_W-1:0] addr;
    } wr_pipe_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS));
        return base + ADDR_W'(col);
    endfunction

endpackage

@@ rtl/tcw_cmd_if.sv @@
// Interface: command channel carrying one console operation per beat.
`timescale 1ns / 1ps
interface tcw_cmd_if;
    import tcw_pkg::*;

    logic valid;
    logic ready;
    cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/tcw_rsp_if.sv @@
// Interface: response channel carrying cursor and read data per beat.
`timescale 1ns / 1ps
interface tcw_rsp_if;
    import tcw_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/tcw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

@@ rtl/text_console_writer_core.sv @@
// Top level: text console writer over an 80x25 cell store.
//
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------
//  cmd     | in  | operation, char_code, target_col, target_row
//  rsp     | out | cursor_col, cursor_row, read_char, read_attr
//
//  Set cursor: accept, result. Read cell: accept, capture, result. Put
//  character: accept, decode, store write, result; a control byte that writes
//  no cell skips the store write. A scroll and a clear each sweep every cell
//  through the single write port of the cell RAM. After reset a clearing pass
//  fills the store before the first command is taken. The result register lets
//  a new command be accepted while the previous result stalls.
`timescale 1ns / 1ps
module text_console_writer_core (
    input  logic     clk,
    input  logic     rst_n,
    tcw_cmd_if.sink  cmd,
    tcw_rsp_if.source rsp
);
    import tcw_pkg::*;

    state_t            state_reg, state_next;
    ret_t              ret_reg, ret_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              copy_reg, copy_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [7:0]        ch_reg, ch_next;
    logic [7:0]        wch_reg, wch_next;
    logic [7:0]        rchar_reg, rchar_next;
    logic [7:0]        rattr_reg, rattr_next;
    wr_pipe_t          pipe_reg, pipe_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_data_reg, out_data_next;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] rd_data;
    logic [CELL_W-1:0] wr_data;

    logic [COL_W-1:0]  tc_sat;
    logic [ROW_W-1:0]  tr_sat;
    logic [COL_W-1:0]  col_w;
    logic [ROW_W-1:0]  row_w;
    logic              wrap;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (pipe_reg.valid),
        .wr_addr (pipe_reg.addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        unique case (pipe_reg.mode)
            WR_COPY: wr_data = rd_data;
            WR_CHAR: wr_data = {rd_data[15:8], wch_reg};
            default: wr_data = BLANK_CELL;
        endcase
    end

    assign tc_sat = (cmd.data.target_col > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1)
                                                                : cmd.data.target_col;
    assign tr_sat = (cmd.data.target_row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1)
                                                             : cmd.data.target_row;

    assign wrap  = (col_reg >= COL_W'(COLUMNS));
    assign col_w = wrap ? '0 : col_reg;
    assign row_w = wrap ? row_reg + ROW_W'(1) : row_reg;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        cnt_next       = cnt_reg;
        copy_next      = copy_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        ch_next        = ch_reg;
        wch_next       = wch_reg;
        rchar_next     = rchar_reg;
        rattr_next     = rattr_reg;
        pipe_next      = '0;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_SWEEP:
            begin
                pipe_next.valid = 1'b1;
                pipe_next.addr  = cnt_reg;
                if (copy_reg && (cnt_reg < ADDR_W'(CELLS - COLUMNS)))
                begin
                    rd_en          = 1'b1;
                    rd_addr        = cnt_reg + ADDR_W'(COLUMNS);
                    pipe_next.mode = WR_COPY;
                end
                else
                begin
                    pipe_next.mode = WR_BLANK;
                end
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end

            ST_DRAIN:
            begin
                unique case (ret_reg)
                    RET_PUT:  state_next = ST_PUT;
                    RET_DONE: state_next = ST_DONE;
                    default:  state_next = ST_IDLE;
                endcase
            end

            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    ch_next    = cmd.data.char_code;
                    rchar_next = '0;
                    rattr_next = '0;
                    unique case (cmd.data.operation)
                        OP_PUT:
                        begin
                            if ((row_reg == ROW_W'(ROWS - 1)) && wrap)
                            begin
                                col_next   = '0;
                                cnt_next   = '0;
                                copy_next  = 1'b1;
                                ret_next   = RET_PUT;
                                state_next = ST_SWEEP;
                            end
                            else
                            begin
                                state_next = ST_PUT;
                            end
                        end
                        OP_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            cnt_next   = '0;
                            copy_next  = 1'b0;
                            ret_next   = RET_DONE;
                            state_next = ST_SWEEP;
                        end
                        OP_SET:
                        begin
                            col_next   = tc_sat;
                            row_next   = tr_sat;
                            state_next = ST_DONE;
                        end
                        OP_READ:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = cell_addr(tr_sat, tc_sat);
                            state_next = ST_RDCAP;
                        end
                    endcase
                end
            end

            ST_PUT:
            begin
                ret_next = RET_DONE;
                priority if (ch_reg == CH_CR)
                begin
                    state_next = ST_DONE;
                end
                else if (ch_reg == CH_LF)
                begin
                    col_next = '0;
                    if (row_w == ROW_W'(ROWS - 1))
                    begin
                        row_next   = row_w;
                        cnt_next   = '0;
                        copy_next  = 1'b1;
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        row_next   = row_w + ROW_W'(1);
                        state_next = ST_DONE;
                    end
                end
                else if (ch_reg == CH_NUL)
                begin
                    col_next   = col_w;
                    row_next   = row_w;
                    state_next = ST_DONE;
                end
                else if (ch_reg == CH_BS)
                begin
                    wch_next = CH_SPACE;
                    if (col_w == '0)
                    begin
                        if (row_w == '0)
                        begin
                            col_next   = col_w;
                            row_next   = row_w;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            row_next        = row_w - ROW_W'(1);
                            col_next        = COL_W'(COLUMNS - 1);
                            rd_en           = 1'b1;
                            rd_addr         = cell_addr(row_w - ROW_W'(1),
                                                        COL_W'(COLUMNS - 1));
                            pipe_next.valid = 1'b1;
                            pipe_next.mode  = WR_CHAR;
                            pipe_next.addr  = rd_addr;
                            state_next      = ST_DRAIN;
                        end
                    end
                    else
                    begin
                        row_next        = row_w;
                        col_next        = col_w - COL_W'(1);
                        rd_en           = 1'b1;
                        rd_addr         = cell_addr(row_w, col_w - COL_W'(1));
                        pipe_next.valid = 1'b1;
                        pipe_next.mode  = WR_CHAR;
                        pipe_next.addr  = rd_addr;
                        state_next      = ST_DRAIN;
                    end
                end
                else
                begin
                    wch_next        = ch_reg;
                    row_next        = row_w;
                    col_next        = col_w + COL_W'(1);
                    rd_en           = 1'b1;
                    rd_addr         = cell_addr(row_w, col_w);
                    pipe_next.valid = 1'b1;
                    pipe_next.mode  = WR_CHAR;
                    pipe_next.addr  = rd_addr;
                    state_next      = ST_DRAIN;
                end
            end

            ST_RDCAP:
            begin
                rchar_next = rd_data[7:0];
                rattr_next = rd_data[15:8];
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.cursor_col = col_reg;
                    out_data_next.cursor_row = row_reg;
                    out_data_next.read_char  = rchar_reg;
                    out_data_next.read_attr  = rattr_reg;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            ret_reg       <= RET_IDLE;
            cnt_reg       <= '0;
            copy_reg      <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            pipe_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            cnt_reg       <= cnt_next;
            copy_reg      <= copy_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            pipe_reg      <= pipe_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg       <= ch_next;
        wch_reg      <= wch_next;
        rchar_reg    <= rchar_next;
        rattr_reg    <= rattr_next;
        out_data_reg <= out_data_next;
    end
endmodule

@@ rtl/tcw_checker.sv @@
// Checker: port-level properties of the text console writer, bound to the top.
`timescale 1ns / 1ps
module tcw_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input tcw_pkg::rsp_t rsp_data
);
    import tcw_pkg::*;

    logic [1:0] pend_reg, pend_next;
    logic       cmd_beat;
    logic       rsp_beat;

    assign cmd_beat = cmd_valid && cmd_ready;
    assign rsp_beat = rsp_valid && rsp_ready;

    always_comb
    begin
        pend_next = pend_reg + {1'b0, cmd_beat} - {1'b0, rsp_beat};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("rsp beat changed while stalled");

    // at most one result waiting plus one command in work
    a_pend_max: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many commands outstanding");

    // no result without a command behind it
    a_rsp_owed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("rsp beat without command");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.cursor_col <= COL_W'(COLUMNS))
                      && (rsp_data.cursor_row <= ROW_W'(ROWS - 1)))
        else $error("cursor out of range");
endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

@@ dv/tb_text_console_writer_core.sv @@
// Testbench: directed and random console commands checked against a cell-store predictor.
`timescale 1ns / 1ps
module tb_text_console_writer_core;
    import tcw_pkg::*;

    class console_scoreboard;
        logic [CELL_W-1:0] cells [CELLS];
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        rsp_t              expected_q [$];
        int                errors;
        int                checked;
        int                scrolls;
        int                clears;
        int                reads;
        int                puts;

        function new();
            wipe();
        endfunction

        function void wipe();
            foreach (cells[k])
                cells[k] = BLANK_CELL;
            col = '0;
            row = '0;
        endfunction

        function void roll_up();
            for (int k = 0; k < (ROWS - 1) * COLUMNS; k++)
                cells[k] = cells[k + COLUMNS];
            for (int k = (ROWS - 1) * COLUMNS; k < CELLS; k++)
                cells[k] = BLANK_CELL;
            col = '0;
            scrolls++;
        endfunction

        function void blank_char(int r, int c);
            cells[r * COLUMNS + c][7:0] = CH_SPACE;
        endfunction

        function void put_char(logic [7:0] ch);
            if (row == ROWS - 1 && col >= COLUMNS)
                roll_up();
            if (ch == CH_CR)
                return;
            if (col >= COLUMNS)
            begin
                row++;
                col = '0;
            end
            if (ch == CH_LF)
            begin
                if (row == ROWS - 1)
                    roll_up();
                else
                begin
                    row++;
                    col = '0;
                end
                return;
            end
            if (ch == CH_NUL)
                return;
            if (ch == CH_BS)
            begin
                if (col == 0)
                begin
                    if (row == 0)
                        return;
                    row--;
                    col = COL_W'(COLUMNS - 1);
                    blank_char(int'(row), int'(col));
                    return;
                end
                blank_char(int'(row), int'(col) - 1);
                col--;
                return;
            end
            cells[row * COLUMNS + col][7:0] = ch;
            col++;
        endfunction

        function void note_cmd(cmd_t c);
            int   tc;
            int   tr;
            rsp_t want;
            tc = (c.target_col > COLUMNS - 1) ? COLUMNS - 1 : c.target_col;
            tr = (c.target_row > ROWS - 1) ? ROWS - 1 : c.target_row;
            want = '0;
            case (c.operation)
                OP_PUT:
                begin
                    put_char(c.char_code);
                    puts++;
                end
                OP_CLEAR:
                begin
                    wipe();
                    clears++;
                end
                OP_SET:
                begin
                    col = COL_W'(tc);
                    row = ROW_W'(tr);
                end
                default:
                begin
                    want.read_char = cells[tr * COLUMNS + tc][7:0];
                    want.read_attr = cells[tr * COLUMNS + tc][15:8];
                    reads++;
                end
            endcase
            want.cursor_col = col;
            want.cursor_row = row;
            expected_q.push_back(want);
        endfunction

        function void field_err(string name, logic [7:0] want, logic [7:0] got);
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        endfunction

        function void check_rsp(rsp_t got);
            rsp_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t ns: response with nothing expected, actual %0h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.cursor_col !== want.cursor_col)
                field_err("cursor_col", 8'(want.cursor_col), 8'(got.cursor_col));
            if (got.cursor_row !== want.cursor_row)
                field_err("cursor_row", 8'(want.cursor_row), 8'(got.cursor_row));
            if (got.read_char !== want.read_char)
                field_err("read_char", want.read_char, got.read_char);
            if (got.read_attr !== want.read_attr)
                field_err("read_attr", want.read_attr, got.read_attr);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic calm;

    tcw_cmd_if cmd ();
    tcw_rsp_if rsp ();

    console_scoreboard sb;

    text_console_writer_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
        rsp.ready <= calm || ($urandom_range(99) >= 32);

    always @(posedge clk)
        if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
            sb.check_rsp(rsp.data);

    function automatic cmd_t mk(op_t op, logic [7:0] ch, logic [COL_W-1:0] tc,
                                logic [ROW_W-1:0] tr);
        cmd_t c;
        c.operation  = op;
        c.char_code  = ch;
        c.target_col = tc;
        c.target_row = tr;
        return c;
    endfunction

    task automatic send_cmd(cmd_t c);
        while (!calm && $urandom_range(99) < 32)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.data  <= c;
        do
            @(posedge clk);
        while (cmd.ready !== 1'b1);
        sb.note_cmd(c);
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
        @(posedge clk);
    endtask

    function automatic logic [COL_W-1:0] pick_col();
        case ($urandom_range(3))
            0: return COL_W'($urandom_range(127));
            1: return COL_W'($urandom_range(COLUMNS - 1, COLUMNS - 4));
            2: return COL_W'($urandom_range(COLUMNS - 1));
            default: return COL_W'($urandom_range(127, COLUMNS));
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] pick_row();
        case ($urandom_range(3))
            0: return ROW_W'($urandom_range(31));
            1: return ROW_W'($urandom_range(ROWS - 1, ROWS - 3));
            2: return ROW_W'($urandom_range(ROWS - 1));
            default: return ROW_W'($urandom_range(31, ROWS));
        endcase
    endfunction

    function automatic cmd_t next_cmd();
        cmd_t c;
        int   sel;
        c   = mk(OP_PUT, 8'($urandom_range(255)), COL_W'($urandom_range(127)),
                 ROW_W'($urandom_range(31)));
        sel = $urandom_range(99);
        if (sel < 2)
            c.operation = OP_CLEAR;
        else if (sel < 14)
        begin
            c.operation  = OP_SET;
            c.target_col = pick_col();
            c.target_row = pick_row();
        end
        else if (sel < 40)
        begin
            c.operation = OP_READ;
            if ($urandom_range(1) == 1)
            begin
                c.target_col = (sb.col == 0) ? '0 : COL_W'(sb.col - 1);
                c.target_row = sb.row;
            end
        end
        else
        begin
            case ($urandom_range(19))
                0, 1:    c.char_code = CH_LF;
                2, 3:    c.char_code = CH_BS;
                4:       c.char_code = CH_CR;
                5:       c.char_code = CH_NUL;
                6, 7:    c.char_code = 8'($urandom_range(255));
                default: c.char_code = 8'($urandom_range(8'h7e, 8'h20));
            endcase
        end
        return c;
    endfunction

    initial
    begin
        #400_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        cmd_t c;
        sb        = new();
        clk       = 1'b0;
        rst_n     = 1'b0;
        calm      = 1'b0;
        cmd.valid = 1'b0;
        cmd.data  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // blank store, saturated read, CR/NUL/BS edge cases, wraps and scrolls
        send_cmd(mk(OP_READ,  8'h00, 7'd0,   5'd0));
        send_cmd(mk(OP_READ,  8'h00, 7'd127, 5'd31));
        send_cmd(mk(OP_PUT,   8'h41, 7'd0,   5'd0));
        send_cmd(mk(OP_PUT,   CH_NUL, 7'd0,  5'd0));
        send_cmd(mk(OP_PUT,   CH_CR, 7'd0,   5'd0));
        send_cmd(mk(OP_PUT,   CH_BS, 7'd0,   5'd0));
        send_cmd(mk(OP_PUT,   CH_BS, 7'd0,   5'd0));
        send_cmd(mk(OP_SET,   8'h00, 7'd79,  5'd0));
        send_cmd(mk(OP_PUT,   8'hff, 7'd0,   5'd0));
        send_cmd(mk(OP_PUT,   CH_LF, 7'd0,   5'd0));
        send_cmd(mk(OP_SET,   8'h00, 7'd79,  5'd1));
        send_cmd(mk(OP_PUT,   8'h79, 7'd0,   5'd0));
        send_cmd(mk(OP_PUT,   8'h7a, 7'd0,   5'd0));
        send_cmd(mk(OP_SET,   8'h00, 7'd0,   5'd1));
        send_cmd(mk(OP_PUT,   CH_BS, 7'd0,   5'd0));
        send_cmd(mk(OP_READ,  8'h00, 7'd79,  5'd0));
        send_cmd(mk(OP_SET,   8'h00, 7'd127, 5'd31));
        send_cmd(mk(OP_PUT,   8'h80, 7'd0,   5'd0));
        send_cmd(mk(OP_PUT,   CH_CR, 7'd0,   5'd0));
        send_cmd(mk(OP_PUT,   8'h77, 7'd0,   5'd0));
        send_cmd(mk(OP_SET,   8'h00, 7'd79,  5'd24));
        send_cmd(mk(OP_PUT,   8'h65, 7'd0,   5'd0));
        send_cmd(mk(OP_PUT,   8'h72, 7'd0,   5'd0));
        send_cmd(mk(OP_PUT,   CH_LF, 7'd0,   5'd0));
        send_cmd(mk(OP_READ,  8'h00, 7'd78,  5'd22));
        send_cmd(mk(OP_CLEAR, 8'h00, 7'd0,   5'd0));
        send_cmd(mk(OP_READ,  8'h00, 7'd0,   5'd0));
        drain();

        for (int n = 0; n < 1500; n++)
        begin
            calm = (n >= 600 && n < 900);
            c    = next_cmd();
            if (c.operation == OP_CLEAR && $urandom_range(1) == 1)
                drain();
            send_cmd(c);
        end
        calm = 1'b0;
        drain();
        repeat (20) @(posedge clk);

        $display("Checked %0d beats: %0d puts, %0d reads, %0d clears, %0d scrolls.",
                 sb.checked, sb.puts, sb.reads, sb.clears, sb.scrolls);
        $display("Stimulus covered control characters, wrap, backspace and saturated targets.");
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/tcw_pkg.sv
rtl/tcw_cmd_if.sv
rtl/tcw_rsp_if.sv
rtl/tcw_ram.sv
rtl/text_console_writer_core.sv
rtl/tcw_checker.sv
dv/tb_text_console_writer_core.sv
